/* hw/rtl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared sizes, codes and controller/datapath interface types for the
// least-recently-used key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int KEY_W   = 16;
   localparam int VAL_W   = 32;
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int REQ_W   = KEY_W + VAL_W;

   localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic exec;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic is_get;
      logic out_free;
   } sts_type;

endpackage

/* hw/rtl/lkvc_ctrl.sv */
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer for one request: accept, key scan, update, response hand-off.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output lkvc_pkg::cmd_type cmd,
   input  lkvc_pkg::sts_type sts
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_EXEC = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.is_get ? S_RESP : S_IDLE;
         end
         S_RESP: begin
            // wait for room in the output register
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/lkvc_dp.sv */
// ----------------------------------------------------------------------------
// lkvc_dp
// Key/value memories, valid bits, recency ranks, entry count, scan
// registers and the output register.
// ----------------------------------------------------------------------------
module lkvc_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  lkvc_pkg::cmd_type            cmd,
   output lkvc_pkg::sts_type            sts,
   input  logic                         req_func,
   input  logic [lkvc_pkg::KEY_W-1:0]   req_key,
   input  logic [lkvc_pkg::VAL_W-1:0]   req_value,
   input  logic                         csr_wen,
   input  logic [lkvc_pkg::CAP_W-1:0]   csr_wdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         rsp_hit,
   output logic [lkvc_pkg::VAL_W-1:0]   rsp_value
);

   localparam int N   = lkvc_pkg::ENTRIES;
   localparam int IW  = lkvc_pkg::IDX_W;
   localparam int CW  = lkvc_pkg::CNT_W;
   localparam int MW  = lkvc_pkg::CMP_W;

   // storage
   logic [lkvc_pkg::KEY_W-1:0] key_mem [N];
   logic [lkvc_pkg::VAL_W-1:0] val_mem [N];

   // request
   logic                       func_ff;
   logic [lkvc_pkg::KEY_W-1:0] key_ff;
   logic [lkvc_pkg::VAL_W-1:0] value_ff;

   // state
   logic [lkvc_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [N-1:0]               valid_ff, valid_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [IW-1:0]              rank_ff [N];
   logic [IW-1:0]              rank_in [N];

   // scan
   logic [CW-1:0]              scan_cnt_ff, scan_cnt_in;
   logic                       cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]              cmp_idx_ff, cmp_idx_in;
   logic [lkvc_pkg::KEY_W-1:0] key_rd_ff;
   logic                       hit_ff, hit_in;
   logic [IW-1:0]              match_idx_ff, match_idx_in;
   logic                       free_found_ff, free_found_in;
   logic [IW-1:0]              free_idx_ff, free_idx_in;
   logic                       vic_found_ff, vic_found_in;
   logic [IW-1:0]              vic_idx_ff, vic_idx_in;
   logic [IW-1:0]              vic_rank_ff, vic_rank_in;

   // response
   logic [lkvc_pkg::VAL_W-1:0] val_rd_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_hit_ff;
   logic [lkvc_pkg::VAL_W-1:0] rsp_value_ff;

   // update
   logic          scan_end;
   logic          cmp_entry_valid;
   logic [IW-1:0] cmp_rank;
   logic [MW-1:0] cap_ext;
   logic [MW-1:0] eff_cap;
   logic          full;
   logic          is_put;
   logic          evict;
   logic          use_victim;
   logic          ins_ok;
   logic [IW-1:0] slot;
   logic          do_touch;
   logic          do_ins;
   logic          mem_we;
   logic [IW-1:0] wr_idx;
   logic [IW-1:0] touch_rank;
   logic [N-1:0]  valid_post;

   assign sts.scan_done = scan_end;
   assign sts.is_get    = (func_ff == lkvc_pkg::FUNC_GET);
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_value  = rsp_value_ff;

   assign cap_in = csr_wen ? csr_wdata : cap_ff;

   // scan sequencing: issue one key read a cycle, compare it in the next cycle
   assign scan_end = (scan_cnt_ff == CW'(N));

   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      if (cmd.load_req) begin
         scan_cnt_in = '0;
      end else if (cmd.scan_step && !scan_end) begin
         scan_cnt_in = scan_cnt_ff + CW'(1);
         cmp_vld_in  = 1'b1;
         cmp_idx_in  = scan_cnt_ff[IW-1:0];
      end
   end

   assign cmp_entry_valid = valid_ff[cmp_idx_ff];
   assign cmp_rank        = rank_ff[cmp_idx_ff];

   always_comb begin
      hit_in        = hit_ff;
      match_idx_in  = match_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      vic_found_in  = vic_found_ff;
      vic_idx_in    = vic_idx_ff;
      vic_rank_in   = vic_rank_ff;
      if (cmd.load_req) begin
         hit_in        = 1'b0;
         free_found_in = 1'b0;
         vic_found_in  = 1'b0;
      end else if (cmp_vld_ff) begin
         if (cmp_entry_valid && (key_rd_ff == key_ff) && !hit_ff) begin
            hit_in       = 1'b1;
            match_idx_in = cmp_idx_ff;
         end
         if (!cmp_entry_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
         // least recent is the largest rank
         if (cmp_entry_valid && (!vic_found_ff || (cmp_rank > vic_rank_ff))) begin
            vic_found_in = 1'b1;
            vic_idx_in   = cmp_idx_ff;
            vic_rank_in  = cmp_rank;
         end
      end
   end

   // effective capacity: zero acts as one, clipped to the entry count
   assign cap_ext = MW'(cap_ff);
   assign eff_cap = (cap_ff == '0) ? MW'(1) : ((cap_ext > MW'(N)) ? MW'(N) : cap_ext);
   assign full    = (MW'(count_ff) >= eff_cap) && (count_ff != '0);

   assign is_put     = (func_ff == lkvc_pkg::FUNC_PUT);
   assign evict      = is_put && !hit_ff && full && vic_found_ff;
   // a lower free slot wins over the evicted one
   assign use_victim = evict && (!free_found_ff || (vic_idx_ff < free_idx_ff));
   assign ins_ok     = use_victim || free_found_ff;
   assign slot       = use_victim ? vic_idx_ff : free_idx_ff;
   assign do_touch   = cmd.exec && hit_ff;
   assign do_ins     = cmd.exec && is_put && !hit_ff && ins_ok;
   assign mem_we     = cmd.exec && is_put && (hit_ff || ins_ok);
   assign wr_idx     = hit_ff ? match_idx_ff : slot;
   assign touch_rank = rank_ff[match_idx_ff];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         valid_post[i] = valid_ff[i] && !(evict && (vic_idx_ff == IW'(i)));
      end
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (do_ins) begin
         valid_in       = valid_post;
         valid_in[slot] = 1'b1;
         count_in       = evict ? count_ff : (count_ff + CW'(1));
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         rank_in[i] = rank_ff[i];
         if (do_touch) begin
            if (match_idx_ff == IW'(i)) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < touch_rank)) begin
               rank_in[i] = rank_ff[i] + IW'(1);
            end
         end else if (do_ins) begin
            if (slot == IW'(i)) begin
               rank_in[i] = '0;
            end else if (valid_post[i]) begin
               rank_in[i] = rank_ff[i] + IW'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= lkvc_pkg::CAP_RESET;
         valid_ff      <= '0;
         count_ff      <= '0;
         scan_cnt_ff   <= CW'(N);
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         vic_found_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         scan_cnt_ff   <= scan_cnt_in;
         cmp_vld_ff    <= cmp_vld_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         vic_found_ff  <= vic_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= req_func;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      cmp_idx_ff   <= cmp_idx_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      vic_idx_ff   <= vic_idx_in;
      vic_rank_ff  <= vic_rank_in;
      rank_ff      <= rank_in;
      if (cmd.load_rsp) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= hit_ff ? val_rd_ff : lkvc_pkg::MISS_VALUE;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_idx] <= key_ff;
         val_mem[wr_idx] <= value_ff;
      end
      if (cmp_vld_in) begin
         key_rd_ff <= key_mem[scan_cnt_ff[IW-1:0]];
      end
      if (cmd.exec) begin
         val_rd_ff <= val_mem[match_idx_ff];
      end
   end

`ifndef SYNTHESIS
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count differs from number of valid entries");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(N))
      else $error("entry count above entry total");

   a_hit_entry_valid: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> valid_ff[match_idx_ff])
      else $error("matched entry is not valid");
`endif

endmodule

/* hw/rtl/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// Requests carry a get or put (req_tuser), a 16-bit key and a 32-bit value;
// each get returns one response with hit in rsp_tuser and the stored value,
// or all ones on a miss, while puts return nothing. Each request runs a scan
// of the key memory at one key per cycle, followed by an update step and,
// for a get, a response step that waits for room in the output register.
// A new request is taken while an earlier response still waits on rsp_tready.
// csr_wdata sets the capacity in use (reset 16, zero acts as one); write
// it only while idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [lkvc_pkg::REQ_W-1:0]   req_tdata,  // lookup_key, write_value
   input  logic [0:0]                   req_tuser,  // func
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [lkvc_pkg::VAL_W-1:0]   rsp_tdata,  // read_value
   output logic [0:0]                   rsp_tuser,  // hit
   input  logic                         csr_wen,
   input  logic [lkvc_pkg::CAP_W-1:0]   csr_wdata   // capacity_in_use
);

   lkvc_pkg::cmd_type cmd;
   lkvc_pkg::sts_type sts;

   logic [lkvc_pkg::KEY_W-1:0] req_key;
   logic [lkvc_pkg::VAL_W-1:0] req_value;
   logic                       rsp_hit;

   assign req_key      = req_tdata[lkvc_pkg::KEY_W-1:0];
   assign req_value    = req_tdata[lkvc_pkg::REQ_W-1:lkvc_pkg::KEY_W];
   assign rsp_tuser[0] = rsp_hit;

   lkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   lkvc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_func   (req_tuser[0]),
      .req_key    (req_key),
      .req_value  (req_value),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_hit    (rsp_hit),
      .rsp_value  (rsp_tdata)
   );

endmodule

/* bench/lkvc_checker.sv */
// ----------------------------------------------------------------------------
// lkvc_checker
// Watches the request, response and csr ports of the key-value cache, keeps
// its own copy of the cache contents and recency order, and compares every
// get response with the predicted hit flag and value, oldest first.
// ----------------------------------------------------------------------------
module lkvc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [lkvc_pkg::REQ_W-1:0]    req_tdata,   // lookup_key, write_value
   input  logic [0:0]                    req_tuser,   // func
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [lkvc_pkg::VAL_W-1:0]    rsp_tdata,   // read_value
   input  logic [0:0]                    rsp_tuser,   // hit
   input  logic                          csr_wen,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_wdata,   // capacity_in_use
   output int                            error_count,
   output int                            outstanding,
   output int                            hit_count,
   output int                            miss_count
);

   typedef struct packed {
      logic                       hit;
      logic [lkvc_pkg::VAL_W-1:0] data;
   } read_result_type;

   read_result_type            pending_reads[$];
   logic [lkvc_pkg::KEY_W-1:0] key_mem[lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::VAL_W-1:0] val_mem[lkvc_pkg::ENTRIES];
   bit                         live[lkvc_pkg::ENTRIES];
   int                         age[lkvc_pkg::ENTRIES];
   int                         live_count;
   logic [lkvc_pkg::CAP_W-1:0] capacity;

   // move one entry to the front, entries that were newer grow one older
   task automatic promote(input int slot);
      int r;
      r = age[slot];
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
         if (live[i] && i != slot && age[i] < r)
            age[i]++;
      age[slot] = 0;
   endtask

   task automatic lru_update(input logic func, input logic [lkvc_pkg::KEY_W-1:0] key,
                             input logic [lkvc_pkg::VAL_W-1:0] data);
      int slot;
      int victim;
      int limit;
      read_result_type res;
      slot = -1;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
         if (slot < 0 && live[i] && key_mem[i] == key)
            slot = i;
      if (func == lkvc_pkg::FUNC_GET) begin
         if (slot >= 0) begin
            promote(slot);
            res.hit  = 1'b1;
            res.data = val_mem[slot];
         end else begin
            res.hit  = 1'b0;
            res.data = lkvc_pkg::MISS_VALUE;
         end
         pending_reads.push_back(res);
      end else if (slot >= 0) begin
         val_mem[slot] = data;
         promote(slot);
      end else begin
         limit = (capacity == 0) ? 1 :
                 (capacity > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : int'(capacity);
         // only the single oldest entry goes, even when capacity was lowered
         if (live_count >= limit && live_count > 0) begin
            victim = -1;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
               if (live[i] && (victim < 0 || age[i] > age[victim]))
                  victim = i;
            if (victim >= 0) begin
               live[victim] = 0;
               live_count--;
            end
         end
         slot = -1;
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (slot < 0 && !live[i])
               slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
               if (live[i])
                  age[i]++;
            live[slot]    = 1;
            key_mem[slot] = key;
            val_mem[slot] = data;
            age[slot]     = 0;
            live_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      read_result_type want;
      if (reset) begin
         pending_reads.delete();
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            live[i] = 0;
            age[i]  = 0;
         end
         live_count  = 0;
         capacity    = lkvc_pkg::CAP_RESET;
         error_count = 0;
         hit_count   = 0;
         miss_count  = 0;
      end else begin
         // responses first: a response never belongs to a request taken on the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reads.size() == 0) begin
               $display("%0t: response with no get waiting: hit %0b value %h",
                        $time, rsp_tuser[0], rsp_tdata);
               error_count++;
            end else begin
               want = pending_reads.pop_front();
               if (rsp_tuser[0] !== want.hit) begin
                  $display("%0t: hit mismatch: expected %0b actual %0b",
                           $time, want.hit, rsp_tuser[0]);
                  error_count++;
               end
               if (rsp_tdata !== want.data) begin
                  $display("%0t: read_value mismatch: expected %h actual %h",
                           $time, want.data, rsp_tdata);
                  error_count++;
               end
               if (want.hit)
                  hit_count++;
               else
                  miss_count++;
            end
         end
         if (csr_wen)
            capacity = csr_wdata;
         if (req_tvalid && req_tready)
            lru_update(req_tuser[0], req_tdata[lkvc_pkg::KEY_W-1:0],
                       req_tdata[lkvc_pkg::REQ_W-1:lkvc_pkg::KEY_W]);
      end
      outstanding <= pending_reads.size();
   end

endmodule

/* bench/tb_lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Drives get and put requests into the key-value cache under changing
// capacity settings and idle patterns, including a long response stall;
// the checker beside the block predicts and compares every get response.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

   localparam int DRAIN_CYCLES    = 30;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int SUB_ITEMS       = 93;
   localparam int POOL_MAX        = 24;

   typedef logic [lkvc_pkg::KEY_W-1:0] key_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [lkvc_pkg::REQ_W-1:0]   req_tdata = '0;    // lookup_key, write_value
   logic [0:0]                   req_tuser = '0;    // func
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [lkvc_pkg::VAL_W-1:0]   rsp_tdata;         // read_value
   logic [0:0]                   rsp_tuser;         // hit
   logic                         csr_wen = 1'b0;
   logic [lkvc_pkg::CAP_W-1:0]   csr_wdata = '0;    // capacity_in_use

   int                           error_count;
   int                           outstanding;
   int                           hit_count;
   int                           miss_count;
   int                           send_idle_pct = 0;
   int                           recv_idle_pct = 0;
   int                           hold_left = 0;
   logic                         rsp_hold_req = 1'b0;
   int                           requests_sent = 0;
   key_type                      key_pool[POOL_MAX];
   logic [lkvc_pkg::CAP_W-1:0]   cap_plan[15] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4,
                                                  5'd8, 5'd2, 5'd17, 5'd12, 5'd16,
                                                  5'd3, 5'd15, 5'd6, 5'd1, 5'd16};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   lru_key_value_cache i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   lkvc_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding),
      .hit_count   (hit_count),
      .miss_count  (miss_count)
   );

   // response side: random back-pressure, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (rsp_hold_req) begin
         rsp_tready <= 1'b0;
         hold_left  <= RSP_HOLD_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(input logic func, input key_type key,
                               input logic [lkvc_pkg::VAL_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {data, key};
      do
         @(posedge clock);
      while (!req_tready);
      requests_sent++;
   endtask

   // all gets answered, then room for a trailing put to finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic run_random(input int count, input logic [lkvc_pkg::CAP_W-1:0] cap);
      int pool_size;
      key_type key;
      pool_size = ((cap == 0) ? 1 :
                   (cap > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : int'(cap))
                  + int'($urandom_range(6));
      if (pool_size > POOL_MAX)
         pool_size = POOL_MAX;
      for (int i = 0; i < POOL_MAX; i++)
         key_pool[i] = key_type'($urandom);
      for (int n = 0; n < count; n++) begin
         // mostly a working set a little bigger than capacity, some stray keys
         if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(pool_size - 1)];
         else
            key = key_type'($urandom);
         send_request($urandom_range(1) ? lkvc_pkg::FUNC_PUT : lkvc_pkg::FUNC_GET,
                      key, $urandom);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cache, field extremes, update in place
      send_request(lkvc_pkg::FUNC_GET, 16'h0000, 32'h0);
      send_request(lkvc_pkg::FUNC_PUT, 16'h0000, 32'h7fff_ffff);
      send_request(lkvc_pkg::FUNC_PUT, 16'hffff, 32'h8000_0000);
      send_request(lkvc_pkg::FUNC_GET, 16'hffff, 32'hffff_ffff);
      send_request(lkvc_pkg::FUNC_GET, 16'h0000, 32'h0);
      send_request(lkvc_pkg::FUNC_PUT, 16'h0000, 32'h0000_0000);
      send_request(lkvc_pkg::FUNC_GET, 16'h0000, 32'h0);
      send_request(lkvc_pkg::FUNC_GET, 16'h1234, 32'h0);
      send_request(lkvc_pkg::FUNC_PUT, 16'h1234, 32'hffff_ffff);
      send_request(lkvc_pkg::FUNC_GET, 16'h1234, 32'h0);

      // capacity zero below the live count: one eviction per new key
      set_capacity(5'd0);
      send_request(lkvc_pkg::FUNC_PUT, 16'h5555, 32'h0123_4567);
      send_request(lkvc_pkg::FUNC_GET, 16'hffff, 32'h0);
      send_request(lkvc_pkg::FUNC_GET, 16'h5555, 32'h0);
      send_request(lkvc_pkg::FUNC_GET, 16'h0000, 32'h0);

      // capacity above the entry count clamps to full size
      set_capacity(5'd31);
      send_request(lkvc_pkg::FUNC_PUT, 16'h0101, 32'hdead_beef);
      send_request(lkvc_pkg::FUNC_PUT, 16'h0202, 32'h5a5a_a5a5);
      send_request(lkvc_pkg::FUNC_GET, 16'h0101, 32'h0);

      set_capacity(5'd1);
      send_request(lkvc_pkg::FUNC_PUT, 16'haaaa, 32'h1111_1111);
      send_request(lkvc_pkg::FUNC_GET, 16'haaaa, 32'h0);
      send_request(lkvc_pkg::FUNC_GET, 16'h0202, 32'h0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 74 : 0;
         recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 16 : 0;
         for (int sub = 0; sub < 5; sub++) begin
            set_capacity(cap_plan[phase * 5 + sub]);
            if (phase == 2 && sub == 0) begin
               // back up the response side so the request side stalls
               rsp_hold_req <= 1'b1;
               @(posedge clock);
               rsp_hold_req <= 1'b0;
            end
            run_random(SUB_ITEMS, cap_plan[phase * 5 + sub]);
         end
      end

      wait_idle();
      $display("sent %0d requests at capacities 0 to 31, checked %0d gets",
               requests_sent, hit_count + miss_count);
      $display("(%0d hits, %0d misses) under idle mixes and one long response hold-off",
               hit_count, miss_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d gets still unanswered", outstanding);
      $display("Verification failed");
      $finish;
   end

endmodule
